// ----- src/dcvd_pkg.sv -----
// ----------------------------------------------------------------------------
// dcvd_pkg
// Shared types, constants and the packed run-level code table of the
// DCT coefficient VLC decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dcvd_pkg;

  localparam int PRIMARY_TABLE_ENTRIES   = 8192;
  localparam int SECONDARY_TABLE_ENTRIES = 512;
  localparam int PACKED_TABLE_LENGTH     = 226;
  localparam int ROM_WORDS  = PRIMARY_TABLE_ENTRIES + SECONDARY_TABLE_ENTRIES;
  localparam int ROM_AW     = $clog2(ROM_WORDS);
  localparam int ROM_DW     = 21;
  localparam int PACK_AW    = $clog2(PACKED_TABLE_LENGTH + 1);
  localparam int RESULT_LIMIT = 17;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_QUANT   = 2'd0;
  localparam logic [1:0] REG_COUNT   = 2'd1;
  localparam logic [1:0] REG_VERSION = 2'd2;

  localparam logic [15:0] EOB_WORD   = 16'hfe00;
  localparam logic [9:0]  DC_TERM    = 10'h1ff;
  localparam logic [1:0]  EOB_PREFIX = 2'b10;
  localparam logic [5:0]  ESC_PREFIX = 6'b000001;

  // ROM fill port
  typedef struct packed {
    logic              we;
    logic [ROM_AW-1:0] addr;
    logic [ROM_DW-1:0] data;
    logic              done;
  } fill_t;

  // Run-length packed table: bits 31..21 repeat count minus one,
  // bits 20..16 code length, bits 15..0 coefficient word.
  localparam logic [31:0] PACKED_ROM [PACKED_TABLE_LENGTH] = '{
    32'h03e00000, 32'h000d000b, 32'h000d03f5, 32'h000d2002, 32'h000d23fe, 32'h000d1003,
    32'h000d13fd, 32'h000d000a, 32'h000d03f6, 32'h000d0804, 32'h000d0bfc, 32'h000d1c02,
    32'h000d1ffe, 32'h000d5402, 32'h000d57fe, 32'h000d5001, 32'h000d53ff, 32'h000d0009,
    32'h000d03f7, 32'h000d4c01, 32'h000d4fff, 32'h000d4801, 32'h000d4bff, 32'h000d0405,
    32'h000d07fb, 32'h000d0c03, 32'h000d0ffd, 32'h000d0008, 32'h000d03f8, 32'h000d1802,
    32'h000d1bfe, 32'h000d4401, 32'h000d47ff, 32'h006b4001, 32'h006b43ff, 32'h006b1402,
    32'h006b17fe, 32'h006b0007, 32'h006b03f9, 32'h006b0803, 32'h006b0bfd, 32'h006b0404,
    32'h006b07fc, 32'h006b3c01, 32'h006b3fff, 32'h006b3801, 32'h006b3bff, 32'h006b1002,
    32'h006b13fe, 32'h0fe00000, 32'h03e80802, 32'h03e80bfe, 32'h03e82401, 32'h03e827ff,
    32'h03e80004, 32'h03e803fc, 32'h03e82001, 32'h03e823ff, 32'h07e71c01, 32'h07e71fff,
    32'h07e71801, 32'h07e71bff, 32'h07e70402, 32'h07e707fe, 32'h07e71401, 32'h07e717ff,
    32'h01e93401, 32'h01e937ff, 32'h01e90006, 32'h01e903fa, 32'h01e93001, 32'h01e933ff,
    32'h01e92c01, 32'h01e92fff, 32'h01e90c02, 32'h01e90ffe, 32'h01e90403, 32'h01e907fd,
    32'h01e90005, 32'h01e903fb, 32'h01e92801, 32'h01e92bff, 32'h0fe60003, 32'h0fe603fd,
    32'h0fe61001, 32'h0fe613ff, 32'h0fe60c01, 32'h0fe60fff, 32'h1fe50002, 32'h1fe503fe,
    32'h1fe50801, 32'h1fe50bff, 32'h3fe40401, 32'h3fe407ff, 32'hffe2fe00, 32'h7fe30001,
    32'h7fe303ff, 32'h03e00000, 32'h00110412, 32'h001107ee, 32'h00110411, 32'h001107ef,
    32'h00110410, 32'h001107f0, 32'h0011040f, 32'h001107f1, 32'h00111803, 32'h00111bfd,
    32'h00114002, 32'h001143fe, 32'h00113c02, 32'h00113ffe, 32'h00113802, 32'h00113bfe,
    32'h00113402, 32'h001137fe, 32'h00113002, 32'h001133fe, 32'h00112c02, 32'h00112ffe,
    32'h00117c01, 32'h00117fff, 32'h00117801, 32'h00117bff, 32'h00117401, 32'h001177ff,
    32'h00117001, 32'h001173ff, 32'h00116c01, 32'h00116fff, 32'h00300028, 32'h003003d8,
    32'h00300027, 32'h003003d9, 32'h00300026, 32'h003003da, 32'h00300025, 32'h003003db,
    32'h00300024, 32'h003003dc, 32'h00300023, 32'h003003dd, 32'h00300022, 32'h003003de,
    32'h00300021, 32'h003003df, 32'h00300020, 32'h003003e0, 32'h0030040e, 32'h003007f2,
    32'h0030040d, 32'h003007f3, 32'h0030040c, 32'h003007f4, 32'h0030040b, 32'h003007f5,
    32'h0030040a, 32'h003007f6, 32'h00300409, 32'h003007f7, 32'h00300408, 32'h003007f8,
    32'h006f001f, 32'h006f03e1, 32'h006f001e, 32'h006f03e2, 32'h006f001d, 32'h006f03e3,
    32'h006f001c, 32'h006f03e4, 32'h006f001b, 32'h006f03e5, 32'h006f001a, 32'h006f03e6,
    32'h006f0019, 32'h006f03e7, 32'h006f0018, 32'h006f03e8, 32'h006f0017, 32'h006f03e9,
    32'h006f0016, 32'h006f03ea, 32'h006f0015, 32'h006f03eb, 32'h006f0014, 32'h006f03ec,
    32'h006f0013, 32'h006f03ed, 32'h006f0012, 32'h006f03ee, 32'h006f0011, 32'h006f03ef,
    32'h006f0010, 32'h006f03f0, 32'h00ee2802, 32'h00ee2bfe, 32'h00ee2402, 32'h00ee27fe,
    32'h00ee1403, 32'h00ee17fd, 32'h00ee0c04, 32'h00ee0ffc, 32'h00ee0805, 32'h00ee0bfb,
    32'h00ee0407, 32'h00ee07f9, 32'h00ee0406, 32'h00ee07fa, 32'h00ee000f, 32'h00ee03f1,
    32'h00ee000e, 32'h00ee03f2, 32'h00ee000d, 32'h00ee03f3, 32'h00ee000c, 32'h00ee03f4,
    32'h00ee6801, 32'h00ee6bff, 32'h00ee6401, 32'h00ee67ff, 32'h00ee6001, 32'h00ee63ff,
    32'h00ee5c01, 32'h00ee5fff, 32'h00ee5801, 32'h00ee5bff
  };

endpackage

`default_nettype wire

// ----- src/dct_coefficient_vlc_decoder_top.sv -----
// ----------------------------------------------------------------------------
// dct_coefficient_vlc_decoder_top
// Run-level VLC decoder for DCT coefficient streams.
// ----------------------------------------------------------------------------
// After reset the code lookup RAM is loaded from the packed table. No input
// word is taken during the load, but register writes are. Each input word
// taken while 32 bits or fewer are buffered is halfword-swapped and appended
// to a 64-bit bit buffer. Codes are then decoded one at a time while 32 bits
// or more remain buffered, and one coefficient word leaves per code. DC,
// end-of-block and escape codes are consumed directly in the decode state.
// Table codes take a RAM read, then the consume. A word is accepted in the
// idle state, and a final check ends decoding and returns there. A waiting
// result held by out_tready stalls decoding. Output results are registered,
// so the next word is accepted while the last result still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module dct_coefficient_vlc_decoder_top
  import dcvd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] stream_word
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] coefficient_word
  output logic             out_tlast,  // stream_done
  output logic [1:0]       out_tuser,  // [0] decode_error, [1] terminator_seen
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_LOOK   = 2'd2;

  fill_t fill;

  logic [1:0]  state_r, state_nxt;
  logic [63:0] buf_r, buf_nxt;
  logic [6:0]  vbc_r, vbc_nxt;
  logic        inside_r, inside_nxt;
  logic [16:0] left_r, left_nxt;
  logic        fin_r, fin_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [5:0]  quant_r;
  logic [16:0] ohw_r;
  logic        v3_r;
  logic        ov_r, ov_nxt;
  logic [15:0] oc_r, oc_nxt;
  logic        od_r, od_nxt;
  logic        oe_r, oe_nxt;
  logic        ot_r, ot_nxt;

  logic [63:0] sh_in, sh_out;
  logic [5:0]  sh_amt;
  logic [31:0] top;
  logic [ROM_AW-1:0] raddr;
  logic [ROM_DW-1:0] rdata;
  logic        in_xfer, cfg_wr, slot, go;
  logic [31:0] swapped;

  dcvd_rom_fill u_fill (
    .clk  (clk),
    .rst_n(rst_n),
    .fill (fill)
  );

  dcvd_ram #(.WIDTH(ROM_DW), .DEPTH(ROM_WORDS)) u_rom (
    .clk  (clk),
    .we   (fill.we),
    .waddr(fill.addr),
    .wdata(fill.data),
    .raddr(raddr),
    .rdata(rdata)
  );

  dcvd_shifter u_sh (
    .din (sh_in),
    .amt (sh_amt),
    .dout(sh_out)
  );

  assign top       = buf_r[63:32];
  assign swapped   = {in_tdata[15:0], in_tdata[31:16]};
  assign in_tready = (state_r == S_IDLE) && fill.done;
  assign in_xfer   = in_tvalid && in_tready;
  assign slot      = !ov_r || out_tready;
  assign go        = !fin_r && (left_r != '0) && (vbc_r >= 7'd32) &&
                     (cnt_r < 5'(RESULT_LIMIT));

  // table index from the leading code bits
  always_comb begin
    if (top[31:24] != '0) begin
      raddr = {1'b0, top[31:19]};
    end else begin
      raddr = ROM_AW'(PRIMARY_TABLE_ENTRIES) + ROM_AW'(top[23:15]);
    end
  end

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_QUANT:   prdata = {26'b0, quant_r};
      REG_COUNT:   prdata = {15'b0, ohw_r};
      REG_VERSION: prdata = {31'b0, v3_r};
      default:     prdata = '0;
    endcase
  end

  // decode sequencer
  always_comb begin
    state_nxt  = state_r;
    buf_nxt    = buf_r;
    vbc_nxt    = vbc_r;
    inside_nxt = inside_r;
    left_nxt   = left_r;
    fin_nxt    = fin_r;
    cnt_nxt    = cnt_r;
    ov_nxt     = ov_r && !out_tready;
    oc_nxt     = oc_r;
    od_nxt     = od_r;
    oe_nxt     = oe_r;
    ot_nxt     = ot_r;
    sh_in      = buf_r;
    sh_amt     = '0;

    case (state_r)
      S_IDLE: begin
        sh_in  = {32'b0, swapped};
        sh_amt = 6'(7'd32 - vbc_r);
        if (in_xfer && !fin_r && (left_r != '0)) begin
          cnt_nxt   = '0;
          state_nxt = S_DECODE;
          if (vbc_r <= 7'd32) begin
            buf_nxt = buf_r | sh_out;
            vbc_nxt = vbc_r + 7'd32;
          end
        end
      end
      S_DECODE: begin
        if (!go) begin
          state_nxt = S_IDLE;
        end else if (slot) begin
          oc_nxt = '0;
          od_nxt = 1'b0;
          oe_nxt = 1'b0;
          ot_nxt = 1'b0;
          if (!inside_r) begin
            if (v3_r) begin
              ov_nxt  = 1'b1;
              od_nxt  = 1'b1;
              oe_nxt  = 1'b1;
              fin_nxt = 1'b1;
            end else if (top[31:22] == DC_TERM) begin
              ov_nxt  = 1'b1;
              od_nxt  = 1'b1;
              ot_nxt  = 1'b1;
              fin_nxt = 1'b1;
            end else begin
              sh_amt     = 6'd10;
              buf_nxt    = sh_out;
              vbc_nxt    = vbc_r - 7'd10;
              inside_nxt = 1'b1;
              oc_nxt     = {quant_r, top[31:22]};
              ov_nxt     = 1'b1;
              od_nxt     = (left_r == 17'd1);
              left_nxt   = left_r - 1'b1;
              cnt_nxt    = cnt_r + 1'b1;
            end
          end else if (top[31:30] == EOB_PREFIX) begin
            sh_amt     = 6'd2;
            buf_nxt    = sh_out;
            vbc_nxt    = vbc_r - 7'd2;
            inside_nxt = 1'b0;
            oc_nxt     = EOB_WORD;
            ov_nxt     = 1'b1;
            od_nxt     = (left_r == 17'd1);
            left_nxt   = left_r - 1'b1;
            cnt_nxt    = cnt_r + 1'b1;
          end else if (top[31:26] == ESC_PREFIX) begin
            sh_amt   = 6'd22;
            buf_nxt  = sh_out;
            vbc_nxt  = vbc_r - 7'd22;
            oc_nxt   = top[25:10];
            ov_nxt   = 1'b1;
            od_nxt   = (left_r == 17'd1);
            left_nxt = left_r - 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end else begin
            state_nxt = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        // table entry is back from the RAM; output register is free here
        state_nxt = S_DECODE;
        oc_nxt    = '0;
        od_nxt    = 1'b1;
        oe_nxt    = 1'b0;
        ot_nxt    = 1'b0;
        ov_nxt    = 1'b1;
        if (rdata[20:16] == '0) begin
          oe_nxt  = 1'b1;
          fin_nxt = 1'b1;
        end else begin
          sh_amt   = {1'b0, rdata[20:16]};
          buf_nxt  = sh_out;
          vbc_nxt  = vbc_r - {2'b0, rdata[20:16]};
          oc_nxt   = rdata[15:0];
          od_nxt   = (left_r == 17'd1);
          left_nxt = left_r - 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // count register write reloads the remaining word count
    if (cfg_wr && (paddr[3:2] == REG_COUNT)) begin
      left_nxt = pwdata[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      buf_r    <= '0;
      vbc_r    <= '0;
      inside_r <= 1'b0;
      left_r   <= '0;
      fin_r    <= 1'b0;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
      quant_r  <= '0;
      ohw_r    <= '0;
      v3_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      buf_r    <= buf_nxt;
      vbc_r    <= vbc_nxt;
      inside_r <= inside_nxt;
      left_r   <= left_nxt;
      fin_r    <= fin_nxt;
      cnt_r    <= cnt_nxt;
      ov_r     <= ov_nxt;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_QUANT:   quant_r <= pwdata[5:0];
          REG_COUNT:   ohw_r   <= pwdata[16:0];
          REG_VERSION: v3_r    <= pwdata[0];
          default:     ;
        endcase
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    oc_r <= oc_nxt;
    od_r <= od_nxt;
    oe_r <= oe_nxt;
    ot_r <= ot_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = oc_r;
  assign out_tlast  = od_r;
  assign out_tuser  = {ot_r, oe_r};

endmodule

`default_nettype wire

// ----- src/dcvd_ram.sv -----
// ----------------------------------------------------------------------------
// dcvd_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dcvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/dcvd_rom_fill.sv -----
// ----------------------------------------------------------------------------
// dcvd_rom_fill
// Expands the run-length packed code table into the lookup RAM after reset,
// one word per cycle; zero-fills any words past the packed runs.
// ----------------------------------------------------------------------------
`default_nettype none

module dcvd_rom_fill
  import dcvd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  output fill_t     fill
);

  logic [PACK_AW-1:0] pidx_r, pidx_nxt;
  logic [10:0]        rep_r, rep_nxt;
  logic [ROM_AW-1:0]  addr_r, addr_nxt;
  logic               busy_r, busy_nxt;
  logic [31:0]        pk;
  logic               in_runs;

  // current packed entry, zero once the runs are exhausted
  assign in_runs = (pidx_r < PACK_AW'(PACKED_TABLE_LENGTH));
  always_comb begin
    pk = '0;
    if (in_runs) begin
      pk = PACKED_ROM[pidx_r[PACK_AW-1:0]];
    end
  end

  always_comb begin
    pidx_nxt = pidx_r;
    rep_nxt  = rep_r;
    addr_nxt = addr_r;
    busy_nxt = busy_r;
    if (busy_r) begin
      addr_nxt = addr_r + 1'b1;
      if (in_runs) begin
        if (rep_r == pk[31:21]) begin
          rep_nxt  = '0;
          pidx_nxt = pidx_r + 1'b1;
        end else begin
          rep_nxt = rep_r + 1'b1;
        end
      end
      if (addr_r == ROM_AW'(ROM_WORDS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pidx_r <= '0;
      rep_r  <= '0;
      addr_r <= '0;
      busy_r <= 1'b1;
    end else begin
      pidx_r <= pidx_nxt;
      rep_r  <= rep_nxt;
      addr_r <= addr_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign fill.we   = busy_r;
  assign fill.addr = addr_r;
  assign fill.data = pk[ROM_DW-1:0];
  assign fill.done = !busy_r;

endmodule

`default_nettype wire

// ----- src/dcvd_shifter.sv -----
// ----------------------------------------------------------------------------
// dcvd_shifter
// Shared 64-bit left barrel shifter: aligns new words into the bit buffer
// and drops consumed code bits.
// ----------------------------------------------------------------------------
`default_nettype none

module dcvd_shifter (
  input  wire logic [63:0] din,
  input  wire logic [5:0]  amt,
  output logic      [63:0] dout
);

  assign dout = din << amt;

endmodule

`default_nettype wire

// ----- tb/sv/dct_coefficient_vlc_decoder_top_test.sv -----
// ----------------------------------------------------------------------------
// dct_coefficient_vlc_decoder_top_test
// Self-checking bench for the run-level VLC decoder: builds coded streams of
// DC, table, escape and end-of-block codes with a terminator, invalid-code or
// version-3 end, packs them into stream words, predicts every result and compares each result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dct_coefficient_vlc_decoder_top_test
  import dcvd_pkg::*;
();

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE      = 40;

  typedef struct packed {
    logic [15:0] coef;
    logic        done;
    logic        err;
    logic        term;
  } coef_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dct_coefficient_vlc_decoder_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // decoder mirror state
  logic [20:0]  code_rom [ROM_WORDS];
  logic [63:0]  bitbuf;
  int unsigned  nbits;
  bit           in_blk;
  int unsigned  blk_no;
  int unsigned  left;
  bit           halted;
  logic [5:0]   quant;
  bit           ver3;
  coef_result_t pending_coefs[$];

  // stream generator state
  bit           gen_bits[$];
  bit           gen_in_blk;
  bit           calm;
  int           fails;
  int           cycles;

  initial begin : rom_build
    int pos;
    int reps;
    pos = 0;
    for (int i = 0; i < ROM_WORDS; i++) code_rom[i] = '0;
    for (int i = 0; i < PACKED_TABLE_LENGTH; i++) begin
      reps = int'(PACKED_ROM[i][31:21]) + 1;
      for (int r = 0; r < reps && pos < ROM_WORDS; r++) begin
        code_rom[pos] = PACKED_ROM[i][20:0];
        pos++;
      end
    end
  end

  function automatic void push_coef(logic [15:0] c, bit d, bit e, bit t);
    coef_result_t x;
    x.coef = c; x.done = d; x.err = e; x.term = t;
    pending_coefs.push_back(x);
  endfunction

  function automatic void shift_out(int unsigned n);
    bitbuf = bitbuf << n;
    nbits -= n;
  endfunction

  // Decode everything one accepted stream word makes available
  function automatic void decode_word(logic [31:0] raw);
    logic [31:0] top;
    logic [20:0] ent;
    logic [15:0] c;
    int unsigned idx;
    int unsigned len;
    int          n;
    if (halted || left == 0) return;
    if (nbits <= 32) begin
      bitbuf = bitbuf | ({32'b0, raw[15:0], raw[31:16]} << (32 - nbits));
      nbits += 32;
    end
    n = 0;
    while (!halted && left != 0 && nbits >= 32 && n < RESULT_LIMIT) begin
      top = bitbuf[63:32];
      if (!in_blk) begin
        if (ver3) begin
          push_coef('0, 1'b1, 1'b1, 1'b0); halted = 1; break;
        end
        if (top[31:22] == DC_TERM) begin
          push_coef('0, 1'b1, 1'b0, 1'b1); halted = 1; break;
        end
        c = {quant, top[31:22]};
        shift_out(10);
        in_blk = 1;
      end else if (top[31:30] == EOB_PREFIX) begin
        c = EOB_WORD;
        shift_out(2);
        in_blk = 0;
        blk_no = (blk_no >= 5) ? 0 : blk_no + 1;
      end else if (top[31:26] == ESC_PREFIX) begin
        c = top[25:10];
        shift_out(22);
      end else begin
        if (top[31:24] != 0) idx = 32'(top[31:19]);
        else idx = PRIMARY_TABLE_ENTRIES + 32'(top[23:15]);
        ent = code_rom[idx];
        len = 32'(ent[20:16]);
        if (len == 0 || len > nbits) begin
          push_coef('0, 1'b1, 1'b1, 1'b0); halted = 1; break;
        end
        c = ent[15:0];
        shift_out(len);
      end
      left--;
      push_coef(c, left == 0, 1'b0, 1'b0);
      n++;
    end
  endfunction

  function automatic void gen_push(logic [31:0] v, int len);
    for (int i = len - 1; i >= 0; i--) gen_bits.push_back(v[i]);
  endfunction

  // Append one legal code; table codes are drawn from non-empty ROM entries
  function automatic void gen_code();
    int          r;
    int unsigned idx;
    int unsigned len;
    logic [16:0] win;
    if (!gen_in_blk) begin
      r = $urandom_range(0, 1022);
      gen_push((r == DC_TERM) ? 32'h3ff : r, 10);
      gen_in_blk = 1;
      return;
    end
    r = $urandom_range(0, 9);
    if (r < 2) begin
      gen_push(32'(EOB_PREFIX), 2);
      gen_in_blk = 0;
      return;
    end
    if (r == 2) begin
      gen_push(32'({ESC_PREFIX, 16'($urandom)}), 22);
      return;
    end
    for (int t = 0; t < 200; t++) begin
      if (r == 3) begin
        idx = $urandom_range(0, SECONDARY_TABLE_ENTRIES - 1);
        len = 32'(code_rom[PRIMARY_TABLE_ENTRIES + idx][20:16]);
        if (len >= 9 && len <= 17) begin
          win = {8'b0, idx[8:0]};
          gen_push(32'(win >> (17 - len)), len);
          return;
        end
      end else begin
        idx = $urandom_range(32, PRIMARY_TABLE_ENTRIES - 1);
        len = 32'(code_rom[idx][20:16]);
        if (len >= 2 && len <= 13 && idx[12:11] != EOB_PREFIX &&
            idx[12:7] != ESC_PREFIX && (idx >> (13 - len)) != 0) begin
          gen_push(32'(idx >> (13 - len)), len);
          return;
        end
      end
    end
    gen_push(32'(EOB_PREFIX), 2);
    gen_in_blk = 0;
  endfunction

  // Next stream word; words the block will drop carry random filler
  function automatic logic [31:0] next_word();
    logic [31:0] sw;
    if (halted || left == 0 || nbits > 32) return $urandom;
    while (gen_bits.size() < 32) gen_code();
    for (int i = 31; i >= 0; i--) sw[i] = gen_bits.pop_front();
    return {sw[15:0], sw[31:16]};
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 25) stall_left <= gap_len();
    end
  end

  // result checker
  always @(posedge clk) begin
    coef_result_t x;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_coefs.size() == 0) begin
        $error("unexpected result transfer: coef %h", out_tdata);
        fails++;
      end else begin
        x = pending_coefs.pop_front();
        if (out_tdata !== x.coef) begin
          $error("coefficient_word: expected %h, got %h", x.coef, out_tdata);
          fails++;
        end
        if (out_tlast !== x.done) begin
          $error("stream_done: expected %b, got %b", x.done, out_tlast);
          fails++;
        end
        if (out_tuser[0] !== x.err) begin
          $error("decode_error: expected %b, got %b", x.err, out_tuser[0]);
          fails++;
        end
        if (out_tuser[1] !== x.term) begin
          $error("terminator_seen: expected %b, got %b", x.term, out_tuser[1]);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_word(logic [31:0] w);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    decode_word(w);
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
  endtask

  // wait until every expected result has arrived and the block settles
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    logic [31:0] rd;
    logic [31:0] mask;
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    case (idx)
      REG_QUANT: begin
        quant = v[5:0]; mask = 32'h3f;
      end
      REG_COUNT: begin
        left = 32'(v[16:0]); mask = 32'h1ffff;
      end
      default: begin
        ver3 = v[0]; mask = 32'h1;
      end
    endcase
    // read back
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0; penable <= 1'b0;
    if ((rd & mask) !== (v & mask)) begin
      $error("register %0d readback: expected %h, got %h", idx, v & mask, rd & mask);
      fails++;
    end
  endtask

  task automatic run_stream(logic [5:0] q, int unsigned count);
    reg_write(REG_QUANT, 32'(q));
    reg_write(REG_COUNT, count);
    while (!halted && left != 0) send_word(next_word());
    drain();
  endtask

  // DC extremes, both escape extremes, end-of-block and four random codes
  task automatic test_directed();
    reg_write(REG_VERSION, 0);
    gen_push(0, 10);
    gen_push(32'({ESC_PREFIX, 16'h0000}), 22);
    gen_push(32'({ESC_PREFIX, 16'hffff}), 22);
    gen_push(32'(EOB_PREFIX), 2);
    gen_push(32'h3ff, 10);
    gen_in_blk = 1;
    repeat (4) gen_code();
    gen_push(32'(EOB_PREFIX), 2);
    gen_push(32'h1fe, 10);
    gen_push(32'(EOB_PREFIX), 2);
    gen_in_blk = 0;
    run_stream(6'd63, 24);
    run_stream(6'd0, 1);
  endtask

  // zero count: an incoming word is dropped with no result
  task automatic test_zero_count();
    reg_write(REG_COUNT, 0);
    send_word($urandom);
    drain();
  endtask

  // short counts leave bits buffered, so reloads hit the full-buffer case
  task automatic test_random_streams();
    int sent;
    int q;
    sent = 0;
    for (int ph = 0; sent < 200 && !halted; ph++) begin
      calm = (ph % 5 == 4);
      q = $urandom_range(0, 3);
      q = (q == 0) ? 0 : (q == 1) ? 63 : $urandom_range(0, 63);
      reg_write(REG_QUANT, q);
      reg_write(REG_COUNT, ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                       : $urandom_range(1, 12));
      while (!halted && left != 0) begin
        if (sent == 100) begin
          in_tvalid <= 1'b0;
          while (pending_coefs.size() != 0) @(posedge clk);
        end
        send_word(next_word());
        sent++;
      end
      drain();
    end
    calm = 0;
  endtask

  // one way of ending the stream: terminator, invalid code or version 3
  task automatic test_stream_end();
    int kind;
    kind = $urandom_range(0, 2);
    if (kind == 0) begin
      if (gen_in_blk) gen_push(32'(EOB_PREFIX), 2);
      gen_push(32'(DC_TERM), 10);
      gen_in_blk = 0;
    end else if (kind == 1) begin
      if (!gen_in_blk) gen_push(32'h055, 10);
      gen_push(0, 20);
      gen_in_blk = 1;
    end else begin
      reg_write(REG_VERSION, 1);
    end
    reg_write(REG_COUNT, 131070);
    for (int i = 0; i < 60 && !halted; i++) send_word(next_word());
    drain();
  endtask

  initial begin
    bitbuf = '0; nbits = 0; in_blk = 0; blk_no = 0; left = 0; halted = 0;
    quant = '0; ver3 = 0; gen_in_blk = 0; calm = 0; fails = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_zero_count();
    test_random_streams();
    test_stream_end();
    if (pending_coefs.size() != 0) begin
      $error("%0d expected results never arrived", pending_coefs.size());
      fails++;
    end
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
